### hw/rtl/mrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_pkg: shared types and constants
// Port codes, register indexes, sequencer states and sizes for the mesh
// route compute unit.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int MeshXMaxDef  = 8;
    localparam int MeshYMaxDef  = 8;
    localparam int CostWidthDef = 16;
    localparam int OccWidthDef  = 8;

    localparam logic [2:0] P_LOCAL = 3'd0;
    localparam logic [2:0] P_EAST  = 3'd1;
    localparam logic [2:0] P_WEST  = 3'd2;
    localparam logic [2:0] P_NORTH = 3'd3;
    localparam logic [2:0] P_SOUTH = 3'd4;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_YSIZE = 2'd1;

    localparam logic [1:0] MODE_DOR    = 2'd1;
    localparam logic [1:0] MODE_GREEDY = 2'd2;
    localparam logic [1:0] MODE_MINC   = 2'd3;

    localparam logic [1:0] DIR_EAST  = 2'd0;
    localparam logic [1:0] DIR_WEST  = 2'd1;
    localparam logic [1:0] DIR_NORTH = 2'd2;
    localparam logic [1:0] DIR_SOUTH = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_DIV, S_DECIDE, S_RD, S_ACC, S_DONE
    } t_state;

endpackage
`default_nettype wire

### hw/rtl/mrc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_divider: restoring divider
// Splits a 6-bit destination id by a 4-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mrc_divider (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [5:0] i_dividend,
    input  wire logic [3:0] i_divisor,
    output logic            o_busy,
    output logic [5:0]      o_quot,
    output logic [3:0]      o_rem
);
    import mrc_pkg::*;

    logic [2:0] r_cnt, n_cnt;
    logic       r_busy, n_busy;
    logic [5:0] r_q, n_q;
    logic [4:0] r_r, n_r;
    logic [3:0] r_d;
    logic [4:0] w_sh;
    logic [5:0] w_diff;

    // one shift/subtract step
    always_comb begin
        w_sh   = {r_r[3:0], r_q[5]};
        w_diff = {1'b0, w_sh} - {2'b0, r_d};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 3'd0;
            n_q    = i_dividend;
            n_r    = 5'd0;
        end else if (r_busy) begin
            if (w_diff[5]) begin
                n_r = w_sh;
                n_q = {r_q[4:0], 1'b0};
            end else begin
                n_r = w_diff[4:0];
                n_q = {r_q[4:0], 1'b1};
            end
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd5) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_start) r_d <= i_divisor;
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_r[3:0];
endmodule
`default_nettype wire

### hw/rtl/mesh_route_compute_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Order: a link write is stored as its beat is taken; a route is answered after
// a 6-step divide and a decision, and min-cost mode then sweeps the quadrant,
// reading and accumulating each cell (up to 64 cells) before the answer.
// Flow: one item at a time; input is held off until the result beat is
// taken. After reset a clearing pass zeroes the link stores before the first
// item is taken.
// ----------------------------------------------------------------------------
// mesh_route_compute_unit: output-port choice for a 2D mesh router
// Dimension order, greedy occupancy and min-cost dynamic programme routing.
// ----------------------------------------------------------------------------
module mesh_route_compute_unit #(
    parameter int MESH_X_MAX = mrc_pkg::MeshXMaxDef,
    parameter int MESH_Y_MAX = mrc_pkg::MeshYMaxDef,
    parameter int COST_WIDTH = mrc_pkg::CostWidthDef,
    parameter int OCC_WIDTH  = mrc_pkg::OccWidthDef
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [3:0]            i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_command,
    input  wire logic [2:0]            i_cur_x,
    input  wire logic [2:0]            i_cur_y,
    input  wire logic [5:0]            i_destination,
    input  wire logic [OCC_WIDTH-1:0]  i_occ_east,
    input  wire logic [OCC_WIDTH-1:0]  i_occ_west,
    input  wire logic [OCC_WIDTH-1:0]  i_occ_north,
    input  wire logic [OCC_WIDTH-1:0]  i_occ_south,
    input  wire logic [1:0]            i_link_dir,
    input  wire logic [2:0]            i_link_x,
    input  wire logic [2:0]            i_link_y,
    input  wire logic [COST_WIDTH-1:0] i_link_cost,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [2:0]                 o_out_port
);
    import mrc_pkg::*;

    localparam int Cells = MESH_X_MAX * MESH_Y_MAX;
    localparam int CW    = $clog2(Cells);
    localparam int XW    = $clog2(MESH_X_MAX);
    localparam int YW    = $clog2(MESH_Y_MAX);
    localparam int PW    = COST_WIDTH + 7;

    // link stores and path scratch
    logic [COST_WIDTH-1:0] m_xcost [Cells];
    logic [COST_WIDTH-1:0] m_wcost [Cells];
    logic [COST_WIDTH-1:0] m_ncost [Cells];
    logic [COST_WIDTH-1:0] m_scost [Cells];
    logic [PW-1:0]         m_path  [Cells];

    t_state r_state, n_state;
    logic [1:0]  r_mode;
    logic [3:0]  r_ysz;
    logic [CW:0] r_clr;
    logic [2:0]  r_cx, r_cy;
    logic [5:0]  r_dest;
    logic [OCC_WIDTH-1:0] r_oe, r_ow, r_on, r_os;
    logic [2:0]  r_port, n_port;
    logic        r_oval;
    logic [3:0]  r_a, r_b, r_nx, r_ny;
    logic        r_xpos, r_ypos;
    logic [4:0]  r_dx, r_dy;
    logic [COST_WIDTH-1:0] r_lcx, r_lcy;
    logic [PW-1:0] r_px, r_py;
    logic        div_start, div_busy;
    logic [5:0]  div_q;
    logic [3:0]  div_r, ysz_eff;

    // effective Y size clamped to 1..MESH_Y_MAX
    always_comb begin
        ysz_eff = r_ysz;
        if (r_ysz == 4'd0) ysz_eff = 4'd1;
        if ({28'd0, r_ysz} > MESH_Y_MAX) ysz_eff = 4'(MESH_Y_MAX);
    end

    mrc_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(r_dest), .i_divisor(ysz_eff),
        .o_busy(div_busy), .o_quot(div_q), .o_rem(div_r)
    );

    // config port
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DOR;
            r_ysz  <= 4'd8;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_MODE) r_mode <= i_cfg_data[1:0];
            else if (i_cfg_index == REG_YSIZE) r_ysz <= i_cfg_data;
        end
    end

    // in-mesh helpers
    function automatic logic inm(input logic [4:0] x, input logic [4:0] y,
                                 input logic [3:0] ys);
        logic ok;
        begin
            ok = !x[4] && !y[4] && ({27'd0, x} < MESH_X_MAX)
                 && ({1'b0, y} < {1'b0, ys}) && ({27'd0, y} < MESH_Y_MAX);
            return ok;
        end
    endfunction

    logic [4:0] cx5, cy5, dx5, dy5;
    assign cx5 = {2'b0, r_cx};
    assign cy5 = {2'b0, r_cy};
    assign dx5 = {div_q[4:0]};
    assign dy5 = {1'b0, div_r};

    logic [2:0] dor_p, grd_p, dec_p;
    logic       go_dp;
    always_comb begin
        logic xe, xw, yn, ys, xo, yo, dxgt, dxlt, dygt, dylt;
        logic [OCC_WIDTH-1:0] xoc, yoc;
        logic [2:0] xp, yp;
        dxgt = {1'b0, div_q} > {4'b0, r_cx};
        dxlt = {1'b0, div_q} < {4'b0, r_cx};
        dygt = div_r > {1'b0, r_cy};
        dylt = div_r < {1'b0, r_cy};
        if (dxgt) dor_p = P_EAST;
        else if (dxlt) dor_p = P_WEST;
        else if (dygt) dor_p = P_NORTH;
        else if (dylt) dor_p = P_SOUTH;
        else dor_p = P_LOCAL;
        xe = !inm(cx5 + 5'd1, cy5, ysz_eff);
        xw = !inm(cx5 - 5'd1, cy5, ysz_eff);
        yn = !inm(cx5, cy5 + 5'd1, ysz_eff);
        ys = !inm(cx5, cy5 - 5'd1, ysz_eff);
        xp  = dxgt ? P_EAST : P_WEST;
        xo  = dxgt ? xe : xw;
        xoc = dxgt ? r_oe : r_ow;
        yp  = dygt ? P_NORTH : P_SOUTH;
        yo  = dygt ? yn : ys;
        yoc = dygt ? r_on : r_os;
        if ((dxgt || dxlt) && (dygt || dylt))
            grd_p = (!xo && (yo || xoc < yoc)) ? xp : yp;
        else
            grd_p = dor_p;
        go_dp = 1'b0;
        case (r_mode)
            MODE_DOR:    dec_p = dor_p;
            MODE_GREEDY: dec_p = grd_p;
            MODE_MINC: begin
                dec_p = dor_p;
                if (dor_p != P_LOCAL && div_q[5] == 1'b0 && inm(cx5, cy5, ysz_eff)
                    && inm(dx5, dy5, ysz_eff))
                    go_dp = 1'b1;
            end
            default:     dec_p = P_LOCAL;
        endcase
    end

    // current DP cell coordinates
    logic [4:0] ci, cj;
    logic [CW-1:0] c_idx, c_xp, c_yp;
    always_comb begin
        ci = r_xpos ? r_dx - {1'b0, r_a} : r_dx + {1'b0, r_a};
        cj = r_ypos ? r_dy - {1'b0, r_b} : r_dy + {1'b0, r_b};
        c_idx = CW'(ci[XW-1:0] * MESH_Y_MAX + cj[YW-1:0]);
        c_xp  = r_xpos ? CW'(c_idx + CW'(MESH_Y_MAX)) : CW'(c_idx - CW'(MESH_Y_MAX));
        c_yp  = r_ypos ? CW'(c_idx + CW'(1)) : CW'(c_idx - CW'(1));
    end

    logic acc_take_y;
    logic [PW-1:0] tx, ty, best;
    assign tx = r_px + PW'(r_lcx);
    assign ty = r_py + PW'(r_lcy);
    always_comb begin
        acc_take_y = (r_a == 4'd0) || ((r_b != 4'd0) && (ty < tx));
        best = acc_take_y ? ty : tx;
    end

    logic acc_in, last_cell;
    assign acc_in   = i_valid && o_ready;
    assign last_cell = (r_a == r_nx) && (r_b == r_ny);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_port    = r_port;
        div_start = 1'b0;
        case (r_state)
            S_CLEAR: if (r_clr == (CW+1)'(Cells - 1)) n_state = S_IDLE;
            S_IDLE: if (acc_in && !i_command) begin
                n_state = S_DIV;
            end
            S_DIV: begin
                div_start = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: if (!div_busy) begin
                n_port  = dec_p;
                n_state = go_dp ? S_ACC : S_DONE;
            end
            S_RD:  n_state = S_ACC;
            S_ACC: begin
                if (!(r_a == 4'd0 && r_b == 4'd0)) n_port = acc_take_y ?
                    (r_ypos ? P_NORTH : P_SOUTH) : (r_xpos ? P_EAST : P_WEST);
                n_state = last_cell ? S_DONE : S_RD;
            end
            S_DONE: if (!r_oval) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // input held off while a result beat waits
    assign o_ready = (r_state == S_IDLE) && !r_oval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + (CW+1)'(1);
            if (r_state == S_DONE && !r_oval) r_oval <= 1'b1;
            else if (r_oval && i_ready) r_oval <= 1'b0;
        end
        r_port <= n_port;
        if (acc_in) begin
            r_cx <= i_cur_x; r_cy <= i_cur_y; r_dest <= i_destination;
            r_oe <= i_occ_east; r_ow <= i_occ_west;
            r_on <= i_occ_north; r_os <= i_occ_south;
        end
        // quadrant set-up, sweep from destination back to current
        if (r_state == S_DECIDE) begin
            r_dx   <= dx5;
            r_dy   <= dy5;
            r_xpos <= {1'b0, div_q} > {4'b0, r_cx};
            r_ypos <= div_r > {1'b0, r_cy};
            r_nx   <= ({1'b0, div_q} > {4'b0, r_cx}) ? 4'(div_q - {3'b0, r_cx})
                                                    : 4'({3'b0, r_cx} - div_q);
            r_ny   <= (div_r > {1'b0, r_cy}) ? 4'(div_r - {1'b0, r_cy})
                                            : 4'({1'b0, r_cy} - div_r);
            r_a <= 4'd0; r_b <= 4'd0;
        end else if (r_state == S_ACC && !last_cell) begin
            if (r_b == r_ny) begin
                r_b <= 4'd0; r_a <= r_a + 4'd1;
            end else r_b <= r_b + 4'd1;
        end
    end

    // memories: stores, swept to zero after reset
    logic [CW-1:0] wr_idx;
    assign wr_idx = CW'({3'b0, i_link_x} * MESH_Y_MAX + {3'b0, i_link_y});
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            m_xcost[r_clr[CW-1:0]] <= '0;
            m_wcost[r_clr[CW-1:0]] <= '0;
            m_ncost[r_clr[CW-1:0]] <= '0;
            m_scost[r_clr[CW-1:0]] <= '0;
        end else if (acc_in && i_command && {29'd0, i_link_x} < MESH_X_MAX
                     && {29'd0, i_link_y} < MESH_Y_MAX) begin
            case (i_link_dir)
                DIR_EAST:  m_xcost[wr_idx] <= i_link_cost;
                DIR_WEST:  m_wcost[wr_idx] <= i_link_cost;
                DIR_NORTH: m_ncost[wr_idx] <= i_link_cost;
                default:   m_scost[wr_idx] <= i_link_cost;
            endcase
        end
        if (r_state == S_RD) begin
            r_lcx <= r_xpos ? m_xcost[c_idx] : m_wcost[c_idx];
            r_lcy <= r_ypos ? m_ncost[c_idx] : m_scost[c_idx];
        end
        // path scratch: two reads in S_RD, one write in S_ACC
        if (r_state == S_RD) begin
            r_px <= m_path[c_xp];
            r_py <= m_path[c_yp];
        end
        if (r_state == S_ACC)
            m_path[c_idx] <= (r_a == 4'd0 && r_b == 4'd0) ? '0 : best;
    end

    assign o_valid    = r_oval;
    assign o_out_port = r_port;

    // checks
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> !o_ready) else $error("ready while result pending");
    a_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> (r_port <= P_SOUTH)) else $error("bad port code");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && !i_ready) |=> $stable(o_out_port)) else $error("port moved");
endmodule
`default_nettype wire

### bench/mrc_route_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_route_checker: port prediction and scoreboard for the route unit
// Watches the register, request and result channels, keeps its own copy of
// the link cost stores and settings, predicts each port and compares it.
// ----------------------------------------------------------------------------
module mrc_route_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic        i_command,
    input  logic [2:0]  i_cur_x,
    input  logic [2:0]  i_cur_y,
    input  logic [5:0]  i_destination,
    input  logic [7:0]  i_occ_east,
    input  logic [7:0]  i_occ_west,
    input  logic [7:0]  i_occ_north,
    input  logic [7:0]  i_occ_south,
    input  logic [1:0]  i_link_dir,
    input  logic [2:0]  i_link_x,
    input  logic [2:0]  i_link_y,
    input  logic [15:0] i_link_cost,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [2:0]  i_out_port,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_routes,
    output int          o_link_writes
);
    import mrc_pkg::*;

    localparam int XMax  = 8;
    localparam int YMax  = 8;
    localparam int Cells = XMax * YMax;

    // Shadow state
    logic [1:0]  mode_q;
    logic [3:0]  ysize_q;
    logic [15:0] east_cost [Cells];
    logic [15:0] west_cost [Cells];
    logic [15:0] north_cost [Cells];
    logic [15:0] south_cost [Cells];
    longint      path_acc [Cells];
    logic [2:0]  port_q [$];

    function automatic bit on_mesh(int x, int y, int ysz);
        return x >= 0 && y >= 0 && x < XMax && y < ysz;
    endfunction

    function automatic logic [2:0] dim_order_port(int cx, int cy, int dx, int dy);
        if (dx > cx) return P_EAST;
        if (dx < cx) return P_WEST;
        if (dy > cy) return P_NORTH;
        if (dy < cy) return P_SOUTH;
        return P_LOCAL;
    endfunction

    // x candidate wins only when in mesh and strictly less loaded (or y is off-mesh)
    function automatic logic [2:0] lighter(logic [2:0] xp, int xo, bit xout,
                                           logic [2:0] yp, int yo, bit yout);
        if (!xout && (yout || xo < yo)) return xp;
        return yp;
    endfunction

    function automatic logic [2:0] greedy_port(int cx, int cy, int dx, int dy, int ysz,
                                               int oe, int ow, int onr, int os);
        bit xe, xw, yn, ys;
        xe = !on_mesh(cx + 1, cy, ysz);
        xw = !on_mesh(cx - 1, cy, ysz);
        yn = !on_mesh(cx, cy + 1, ysz);
        ys = !on_mesh(cx, cy - 1, ysz);
        if (dx > cx) begin
            if (dy > cy) return lighter(P_EAST, oe, xe, P_NORTH, onr, yn);
            if (dy < cy) return lighter(P_EAST, oe, xe, P_SOUTH, os, ys);
            return P_EAST;
        end
        if (dx < cx) begin
            if (dy > cy) return lighter(P_WEST, ow, xw, P_NORTH, onr, yn);
            if (dy < cy) return lighter(P_WEST, ow, xw, P_SOUTH, os, ys);
            return P_WEST;
        end
        return dim_order_port(cx, cy, dx, dy);
    endfunction

    // Cheapest minimal path, filled back from the destination; ties go to X
    function automatic logic [2:0] min_cost_port(int cx, int cy, int dx, int dy, int ysz);
        int         xr, yr, nx, ny, i, j, c;
        logic [2:0] xport, yport, best;
        longint     bestc, t;
        bit         have;
        xr    = (dx > cx) ? -1 : 1;
        yr    = (dy > cy) ? -1 : 1;
        nx    = (dx > cx) ? dx - cx : cx - dx;
        ny    = (dy > cy) ? dy - cy : cy - dy;
        xport = (dx > cx) ? P_EAST : P_WEST;
        yport = (dy > cy) ? P_NORTH : P_SOUTH;
        best  = P_LOCAL;
        if (cx == dx && cy == dy) return P_LOCAL;
        if (!on_mesh(cx, cy, ysz) || !on_mesh(dx, dy, ysz))
            return dim_order_port(cx, cy, dx, dy);
        for (int a = 0; a <= nx; a++) begin
            for (int b = 0; b <= ny; b++) begin
                i     = dx + a * xr;
                j     = dy + b * yr;
                c     = i * YMax + j;
                bestc = 0;
                have  = 0;
                if (a == 0 && b == 0) begin
                    path_acc[c] = 0;
                end else begin
                    if (a > 0) begin
                        bestc = path_acc[(i - xr) * YMax + j] +
                                ((xport == P_EAST) ? east_cost[c] : west_cost[c]);
                        have  = 1;
                        best  = xport;
                    end
                    if (b > 0) begin
                        t = path_acc[i * YMax + j - yr] +
                            ((yport == P_NORTH) ? north_cost[c] : south_cost[c]);
                        if (!have || t < bestc) begin
                            bestc = t;
                            best  = yport;
                        end
                    end
                    path_acc[c] = bestc;
                end
            end
        end
        return best;
    endfunction

    // Sample all three channels on the rising edge
    always @(posedge i_clk) begin
        int         ysz, dx, dy, c;
        logic [2:0] port, want;
        if (!i_rst_n) begin
            mode_q        = MODE_DOR;
            ysize_q       = 4'd8;
            o_mismatches  = 0;
            o_routes      = 0;
            o_link_writes = 0;
            port_q.delete();
            for (int k = 0; k < Cells; k++) begin
                east_cost[k]  = '0;
                west_cost[k]  = '0;
                north_cost[k] = '0;
                south_cost[k] = '0;
                path_acc[k]   = 0;
            end
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_MODE) mode_q = i_cfg_data[1:0];
                else if (i_cfg_index == REG_YSIZE) ysize_q = i_cfg_data;
            end
            if (i_valid && i_ready) begin
                if (i_command) begin
                    c = i_link_x * YMax + i_link_y;
                    case (i_link_dir)
                        DIR_EAST:  east_cost[c]  = i_link_cost;
                        DIR_WEST:  west_cost[c]  = i_link_cost;
                        DIR_NORTH: north_cost[c] = i_link_cost;
                        default:   south_cost[c] = i_link_cost;
                    endcase
                    o_link_writes++;
                end else begin
                    ysz = (ysize_q < 1) ? 1 : (ysize_q > YMax) ? YMax : ysize_q;
                    dx  = i_destination / ysz;
                    dy  = i_destination % ysz;
                    case (mode_q)
                        MODE_DOR:    port = dim_order_port(i_cur_x, i_cur_y, dx, dy);
                        MODE_GREEDY: port = greedy_port(i_cur_x, i_cur_y, dx, dy, ysz,
                                                        i_occ_east, i_occ_west,
                                                        i_occ_north, i_occ_south);
                        MODE_MINC:   port = min_cost_port(i_cur_x, i_cur_y, dx, dy, ysz);
                        default:     port = P_LOCAL;
                    endcase
                    port_q.push_back(port);
                    o_routes++;
                end
            end
            if (i_res_valid && i_res_ready) begin
                if (port_q.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("[%0t] result beat with no route pending: port %0d",
                                 $time, i_out_port);
                end else begin
                    want = port_q.pop_front();
                    if (i_out_port !== want) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("[%0t] port mismatch: expected %0d, got %0d",
                                     $time, want, i_out_port);
                    end
                end
            end
        end
        o_pending = port_q.size();
    end

endmodule

### bench/mesh_route_compute_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_route_compute_unit_tb: stimulus and verdict for the route unit
// Directed routes and link writes, then random traffic across all routing
// modes and a spread of Y sizes with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module mesh_route_compute_unit_tb;
    import mrc_pkg::*;

    localparam logic       CMD_ROUTE = 1'b0;
    localparam logic       CMD_LINK  = 1'b1;
    localparam logic [1:0] REG_SPARE = 2'd2;
    localparam logic [1:0] REG_TOP   = 2'd3;
    localparam int         Drain     = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [3:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_command = 1'b0;
    logic [2:0]  i_cur_x = '0, i_cur_y = '0;
    logic [5:0]  i_destination = '0;
    logic [7:0]  i_occ_east = '0, i_occ_west = '0, i_occ_north = '0, i_occ_south = '0;
    logic [1:0]  i_link_dir = '0;
    logic [2:0]  i_link_x = '0, i_link_y = '0;
    logic [15:0] i_link_cost = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_out_port;

    int mismatches, pending, routes, link_writes;
    int burst_left = 0;
    bit gapless = 0;
    bit hold_off = 0;
    int cur_ysz = 8;

    always #1 i_clk = ~i_clk;

    mesh_route_compute_unit uut (.*);

    mrc_route_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_ready(o_ready), .i_command(i_command),
        .i_cur_x(i_cur_x), .i_cur_y(i_cur_y), .i_destination(i_destination),
        .i_occ_east(i_occ_east), .i_occ_west(i_occ_west),
        .i_occ_north(i_occ_north), .i_occ_south(i_occ_south),
        .i_link_dir(i_link_dir), .i_link_x(i_link_x), .i_link_y(i_link_y),
        .i_link_cost(i_link_cost),
        .i_res_valid(o_valid), .i_res_ready(i_ready), .i_out_port(o_out_port),
        .o_mismatches(mismatches), .o_pending(pending),
        .o_routes(routes), .o_link_writes(link_writes)
    );

    // Receiver: short random stalls, quiet stretches, and the long hold-off
    always @(negedge i_clk) begin
        int stall_left;
        if (hold_off) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if ((($time / 400) % 3 != 0) && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 12);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Long hold-off while requests keep coming, so the unit backs up
    initial begin
        wait (routes >= 150);
        @(negedge i_clk);
        hold_off = 1;
        repeat (400) @(negedge i_clk);
        hold_off = 0;
    end

    // One request beat, with burst and gap shaping ahead of it
    task automatic send_beat(logic cmd, logic [2:0] cx, logic [2:0] cy, logic [5:0] dst,
                             logic [7:0] oe, logic [7:0] ow, logic [7:0] onr,
                             logic [7:0] os, logic [1:0] dir, logic [2:0] lx,
                             logic [2:0] ly, logic [15:0] cost);
        if (burst_left == 0) begin
            if (!gapless) begin
                i_valid = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_command     = cmd;
        i_cur_x       = cx;
        i_cur_y       = cy;
        i_destination = dst;
        i_occ_east    = oe;
        i_occ_west    = ow;
        i_occ_north   = onr;
        i_occ_south   = os;
        i_link_dir    = dir;
        i_link_x      = lx;
        i_link_y      = ly;
        i_link_cost   = cost;
        i_valid       = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_route(logic [2:0] cx, logic [2:0] cy, logic [5:0] dst);
        logic [7:0] oe, ow, onr, os;
        oe  = 8'($urandom);
        ow  = 8'($urandom);
        onr = 8'($urandom);
        os  = 8'($urandom);
        // equal loads now and then to exercise the tie rule
        if ($urandom_range(0, 4) == 0) begin
            ow  = oe;
            onr = oe;
            os  = oe;
        end
        send_beat(CMD_ROUTE, cx, cy, dst, oe, ow, onr, os, 2'($urandom), 3'($urandom),
                  3'($urandom), 16'($urandom));
    endtask

    task automatic send_link(logic [1:0] dir, logic [2:0] lx, logic [2:0] ly,
                             logic [15:0] cost);
        send_beat(CMD_LINK, 3'($urandom), 3'($urandom), 6'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), dir, lx, ly, cost);
    endtask

    // Register write once the unit has drained
    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        i_valid = 1'b0;
        wait (pending == 0);
        repeat (Drain) @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        burst_left = 0;
    endtask

    task automatic set_mode(logic [1:0] m, logic [3:0] ysz);
        write_reg(REG_MODE, {2'($urandom), m});
        write_reg(REG_YSIZE, ysz);
        cur_ysz = (ysz < 1) ? 1 : (ysz > 8) ? 8 : ysz;
    endtask

    task automatic random_phase(int count, int link_pct);
        logic [2:0] cx, cy;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < link_pct) begin
                send_link(2'($urandom), 3'($urandom), 3'($urandom),
                          ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
            end else begin
                cx = 3'($urandom);
                cy = ($urandom_range(0, 5) == 0) ? 3'($urandom)
                                                 : 3'($urandom_range(0, cur_ysz - 1));
                if ($urandom_range(0, 9) == 0)
                    send_route(cx, cy, 6'(cx * cur_ysz + cy));
                else
                    send_route(cx, cy, 6'($urandom));
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed routes under reset settings (dimension order, Y size 8)
        send_route(3'd0, 3'd0, 6'd63);
        send_route(3'd7, 3'd7, 6'd0);
        send_route(3'd3, 3'd5, 6'd29);
        send_route(3'd3, 3'd2, 6'd29);
        send_route(3'd3, 3'd7, 6'd29);
        for (int d = 0; d < 4; d++) begin
            send_link(2'(d), 3'd0, 3'd0, 16'hFFFF);
            send_link(2'(d), 3'd7, 3'd7, 16'h0000);
        end
        // Writes to unused indexes must leave the settings alone
        write_reg(REG_SPARE, 4'hF);
        write_reg(REG_TOP, 4'h0);
        send_route(3'd4, 3'd4, 6'd4);

        set_mode(MODE_GREEDY, 4'd8);
        send_route(3'd7, 3'd7, 6'd0);
        send_route(3'd0, 3'd7, 6'd56);
        send_route(3'd7, 3'd0, 6'd7);
        random_phase(60, 10);

        set_mode(MODE_MINC, 4'd8);
        send_route(3'd0, 3'd0, 6'd63);
        send_route(3'd7, 3'd7, 6'd0);
        gapless = 1;
        random_phase(70, 40);
        gapless = 0;

        set_mode(MODE_MINC, 4'd1);
        random_phase(40, 30);
        set_mode(MODE_GREEDY, 4'd3);
        random_phase(50, 10);
        set_mode(MODE_DOR, 4'd0);
        random_phase(40, 10);
        set_mode(2'd0, 4'd5);
        random_phase(30, 10);
        set_mode(MODE_MINC, 4'd15);
        gapless = 1;
        random_phase(70, 35);
        gapless = 0;
        set_mode(MODE_GREEDY, 4'd1);
        random_phase(40, 10);
        set_mode(MODE_MINC, 4'd4);
        random_phase(60, 35);
        set_mode(MODE_DOR, 4'd9);
        random_phase(50, 10);
        set_mode(MODE_GREEDY, 4'd6);
        random_phase(50, 10);

        i_valid = 1'b0;
        wait (pending == 0);
        repeat (Drain) @(negedge i_clk);
        $display("Covered %0d routes and %0d link cost writes over all modes and Y sizes.",
                 routes, link_writes);
        if (mismatches == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d routes unanswered", mismatches, pending);
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Timed out with %0d routes unanswered", pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_divider.sv
hw/rtl/mesh_route_compute_unit.sv
bench/mrc_route_checker.sv
bench/mesh_route_compute_unit_tb.sv
